/* sv/vpic_pkg.sv */
`timescale 1ns / 1ps

package vpic_pkg;

    // Pressure code width, fixed by the transaction layout
    localparam int C_PRESSURE_BITS = 16;
    localparam int C_LEVEL_BITS    = 16;
    localparam int C_MS_BITS       = 24;
    localparam int C_CFG_IDX_BITS  = 3;
    localparam int C_CFG_DATA_BITS = 24;

    // Op and command codes of an input transaction
    localparam logic       OP_TICK        = 1'b0;
    localparam logic       OP_CMD         = 1'b1;
    localparam logic [1:0] CMD_HALT       = 2'd0;
    localparam logic [1:0] CMD_CLR_GAUGE  = 2'd1;
    localparam logic [1:0] CMD_CLR_FAULTS = 2'd2;
    localparam logic [1:0] CMD_GO         = 2'd3;

    // Configuration register indexes
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_FORE_TRIP  = 3'd0;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_FORE_SAFE  = 3'd1;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_UHV_TRIP   = 3'd2;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_WARMUP     = 3'd3;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_FORE_STBL  = 3'd4;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_OK_DEBOUNCE = 3'd5;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_LOST_TMO   = 3'd6;
    localparam logic [C_CFG_IDX_BITS-1:0] CFG_GAUGE_GRACE = 3'd7;

    typedef enum logic [2:0] {
        MODE_WARM  = 3'd0,
        MODE_IDLE  = 3'd1,
        MODE_START = 3'd2,
        MODE_WAIT  = 3'd3,
        MODE_RUN   = 3'd4,
        MODE_FAULT = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_FORE_TRIP = 4'd1,
        EV_GAUGE_TRIP = 4'd2,
        EV_PUMP_LOST = 4'd3,
        EV_WARM_DONE = 4'd4,
        EV_PUMPS_ON  = 4'd5,
        EV_RUN       = 4'd6,
        EV_ACCEPTED  = 4'd7,
        EV_DENIED    = 4'd8
    } t_event;

    // Classified work for the back end
    typedef enum logic [2:0] {
        JOB_TICK      = 3'd0,
        JOB_STOP      = 3'd1,
        JOB_CLR_GAUGE = 3'd2,
        JOB_RESET     = 3'd3,
        JOB_START     = 3'd4
    } t_job_kind;

    typedef struct packed {
        logic                       op;
        logic [1:0]                 command;
        logic [C_PRESSURE_BITS-1:0] fore_pressure;
        logic [C_PRESSURE_BITS-1:0] uhv_pressure;
        logic                       pump_a_ok;
        logic                       pump_b_ok;
    } t_in_item;

    typedef struct packed {
        logic       pump_a_drive;
        logic       pump_b_drive;
        logic       gauge_drive;
        logic [2:0] mode;
        logic       gauge_fault;
        logic       system_fault;
        logic [3:0] event_res;
    } t_out_item;

    typedef struct packed {
        t_job_kind                  kind;
        logic [C_PRESSURE_BITS-1:0] fore;
        logic [C_PRESSURE_BITS-1:0] uhv;
        logic                       a_ok;
        logic                       b_ok;
    } t_job;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

/* sv/vpic_front.sv */
`timescale 1ns / 1ps

module vpic_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  vpic_pkg::t_in_item i_in,
    output vpic_pkg::t_head  o_head,
    input  logic             i_pop
);
    import vpic_pkg::*;

    localparam int C_DEPTH = 2;

    t_job       r_q [C_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_job       w_job;
    logic       w_push;
    logic       w_pop;

    // Classify the incoming transaction
    always_comb begin
        w_job.fore = i_in.fore_pressure;
        w_job.uhv  = i_in.uhv_pressure;
        w_job.a_ok = i_in.pump_a_ok;
        w_job.b_ok = i_in.pump_b_ok;
        w_job.kind = JOB_TICK;
        if (i_in.op == OP_CMD) begin
            case (i_in.command)
                CMD_HALT:       w_job.kind = JOB_STOP;
                CMD_CLR_GAUGE:  w_job.kind = JOB_CLR_GAUGE;
                CMD_CLR_FAULTS: w_job.kind = JOB_RESET;
                CMD_GO:         w_job.kind = JOB_START;
                default:        w_job.kind = JOB_STOP;
            endcase
        end
    end

    assign o_stall = (r_count == 2'(C_DEPTH));
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.job   = r_q[r_rd_ptr];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(C_DEPTH))
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("queue pop lost");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'(C_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

/* sv/vpic_back.sv */
`timescale 1ns / 1ps

module vpic_back #(
    parameter int TIMER_BITS = 24
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [vpic_pkg::C_CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [vpic_pkg::C_CFG_DATA_BITS-1:0]     i_cfg_data,
    input  vpic_pkg::t_head                          i_head,
    output logic                                     o_pop,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output vpic_pkg::t_out_item                      o_out
);
    import vpic_pkg::*;

    localparam logic [TIMER_BITS-1:0] C_TMAX = {TIMER_BITS{1'b1}};

    // Configuration
    logic [C_LEVEL_BITS-1:0] r_fore_trip, r_fore_safe, r_uhv_trip;
    logic [C_MS_BITS-1:0]    r_warmup, r_fore_stbl, r_ok_deb, r_lost_tmo, r_grace;

    // Sequencer state
    t_mode                 r_mode, n_mode;
    logic                  r_gauge_fault, n_gauge_fault;
    logic                  r_sys_fault, n_sys_fault;
    logic                  r_pump_a, n_pump_a;
    logic                  r_pump_b, n_pump_b;
    logic                  r_gauge, n_gauge;
    logic                  r_gauge_seen, n_gauge_seen;
    logic [TIMER_BITS-1:0] r_boot_t, n_boot_t;
    logic [TIMER_BITS-1:0] r_fsafe_t, n_fsafe_t;
    logic [TIMER_BITS-1:0] r_gon_t, n_gon_t;
    logic [TIMER_BITS-1:0] r_ok_a_t, n_ok_a_t;
    logic [TIMER_BITS-1:0] r_ok_b_t, n_ok_b_t;
    logic [TIMER_BITS-1:0] r_lost_a_t, n_lost_a_t;
    logic [TIMER_BITS-1:0] r_lost_b_t, n_lost_b_t;
    t_event                n_event;

    t_out_item r_out, n_out;
    logic      r_out_valid;
    logic      w_take;
    logic      w_hold_a, w_hold_b, w_gauge_on;
    t_job      w_job;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (t == C_TMAX) ? t : t + 1'b1;
    endfunction

    // Limit compare at a common width, so a limit beyond the timer range never passes
    function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                     input logic [C_MS_BITS-1:0] lim);
        return 32'(t) >= 32'(lim);
    endfunction

    assign w_job   = i_head.job;
    assign w_take  = i_head.valid && (!r_out_valid || !i_stall);
    assign o_pop   = w_take;
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Next state of the sequencer for the transaction at the queue head
    always_comb begin
        n_mode        = r_mode;
        n_gauge_fault = r_gauge_fault;
        n_sys_fault   = r_sys_fault;
        n_pump_a      = r_pump_a;
        n_pump_b      = r_pump_b;
        n_gauge       = r_gauge;
        n_gauge_seen  = r_gauge_seen;
        n_boot_t      = r_boot_t;
        n_fsafe_t     = r_fsafe_t;
        n_gon_t       = r_gon_t;
        n_ok_a_t      = r_ok_a_t;
        n_ok_b_t      = r_ok_b_t;
        n_lost_a_t    = r_lost_a_t;
        n_lost_b_t    = r_lost_b_t;
        n_event       = EV_NONE;
        w_hold_a      = 1'b0;
        w_hold_b      = 1'b0;
        w_gauge_on    = 1'b0;
        case (w_job.kind)
            JOB_TICK: begin
                n_boot_t = sat_inc(r_boot_t);
                if (r_gauge_seen) n_gon_t = sat_inc(r_gon_t);
                // Overpressure trips
                if (!r_sys_fault && (w_job.fore > r_fore_trip)) begin
                    n_sys_fault = 1'b1;
                    n_mode      = MODE_FAULT;
                    n_pump_a    = 1'b0;
                    n_pump_b    = 1'b0;
                    n_gauge     = 1'b0;
                    n_event     = EV_FORE_TRIP;
                end
                if (!r_gauge_fault && (n_mode == MODE_RUN) && n_gauge && r_gauge_seen
                    && (32'(n_gon_t) > 32'(r_grace)) && (w_job.uhv > r_uhv_trip)) begin
                    n_gauge_fault = 1'b1;
                    n_gauge       = 1'b0;
                    n_event       = EV_GAUGE_TRIP;
                end
                // Mode step
                case (n_mode)
                    MODE_WARM: begin
                        n_pump_a = 1'b0;
                        n_pump_b = 1'b0;
                        n_gauge  = 1'b0;
                        if (reached(n_boot_t, r_warmup)) begin
                            n_mode  = MODE_IDLE;
                            n_event = EV_WARM_DONE;
                        end
                    end
                    MODE_IDLE, MODE_FAULT: begin
                        n_pump_a = 1'b0;
                        n_pump_b = 1'b0;
                        n_gauge  = 1'b0;
                    end
                    MODE_START: begin
                        if (w_job.fore <= r_fore_safe) begin
                            w_hold_a  = reached(r_fsafe_t, r_fore_stbl);
                            n_fsafe_t = sat_inc(r_fsafe_t);
                        end else begin
                            n_fsafe_t = '0;
                        end
                        if (w_hold_a) begin
                            n_pump_a   = 1'b1;
                            n_pump_b   = 1'b1;
                            n_ok_a_t   = '0;
                            n_ok_b_t   = '0;
                            n_lost_a_t = '0;
                            n_lost_b_t = '0;
                            n_mode     = MODE_WAIT;
                            n_event    = EV_PUMPS_ON;
                        end else begin
                            n_pump_a = 1'b0;
                            n_pump_b = 1'b0;
                        end
                        n_gauge = 1'b0;
                    end
                    MODE_WAIT: begin
                        n_gauge = 1'b0;
                        if (w_job.a_ok) begin
                            w_hold_a = reached(r_ok_a_t, r_ok_deb);
                            n_ok_a_t = sat_inc(r_ok_a_t);
                        end else begin
                            n_ok_a_t = '0;
                        end
                        if (w_job.b_ok) begin
                            w_hold_b = reached(r_ok_b_t, r_ok_deb);
                            n_ok_b_t = sat_inc(r_ok_b_t);
                        end else begin
                            n_ok_b_t = '0;
                        end
                        if (w_hold_a && w_hold_b) begin
                            n_ok_a_t   = '0;
                            n_ok_b_t   = '0;
                            n_lost_a_t = '0;
                            n_lost_b_t = '0;
                            n_mode     = MODE_RUN;
                            n_event    = EV_RUN;
                        end
                    end
                    MODE_RUN: begin
                        n_pump_a = 1'b1;
                        n_pump_b = 1'b1;
                        if (!w_job.a_ok) begin
                            w_hold_a   = reached(r_lost_a_t, r_lost_tmo);
                            n_lost_a_t = sat_inc(r_lost_a_t);
                        end else begin
                            n_lost_a_t = '0;
                        end
                        if (!w_job.b_ok) begin
                            w_hold_b   = reached(r_lost_b_t, r_lost_tmo);
                            n_lost_b_t = sat_inc(r_lost_b_t);
                        end else begin
                            n_lost_b_t = '0;
                        end
                        if (w_hold_a || w_hold_b) begin
                            n_sys_fault = 1'b1;
                            n_mode      = MODE_FAULT;
                            n_pump_a    = 1'b0;
                            n_pump_b    = 1'b0;
                            n_gauge     = 1'b0;
                            n_event     = EV_PUMP_LOST;
                        end else begin
                            w_gauge_on = !n_gauge_fault && (w_job.a_ok || w_job.b_ok);
                            // Grace window restarts on the gauge relay's rising edge
                            if (w_gauge_on && !n_gauge) begin
                                n_gon_t      = '0;
                                n_gauge_seen = 1'b1;
                            end
                            n_gauge = w_gauge_on;
                        end
                    end
                    default: begin
                        n_sys_fault = 1'b1;
                        n_mode      = MODE_FAULT;
                        n_pump_a    = 1'b0;
                        n_pump_b    = 1'b0;
                        n_gauge     = 1'b0;
                        n_event     = EV_NONE;
                    end
                endcase
            end
            JOB_STOP: begin
                n_pump_a = 1'b0;
                n_pump_b = 1'b0;
                n_gauge  = 1'b0;
                n_mode   = MODE_IDLE;
                n_event  = EV_ACCEPTED;
            end
            JOB_CLR_GAUGE: begin
                if (!r_gauge_fault) begin
                    n_event = EV_DENIED;
                end else begin
                    n_gauge_fault = 1'b0;
                    n_event       = EV_ACCEPTED;
                end
            end
            JOB_RESET: begin
                if ((!r_gauge_fault && !r_sys_fault)
                    || (r_sys_fault && (w_job.fore > r_fore_safe))) begin
                    n_event = EV_DENIED;
                end else begin
                    n_gauge_fault = 1'b0;
                    n_sys_fault   = 1'b0;
                    n_mode        = MODE_IDLE;
                    n_event       = EV_ACCEPTED;
                end
            end
            JOB_START: begin
                if (r_sys_fault || ((r_mode != MODE_IDLE) && (r_mode != MODE_WARM))) begin
                    n_event = EV_DENIED;
                end else begin
                    n_mode    = MODE_START;
                    n_fsafe_t = '0;
                    n_event   = EV_ACCEPTED;
                end
            end
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    // Result fields show the state after the transaction
    always_comb begin
        n_out.pump_a_drive = n_pump_a;
        n_out.pump_b_drive = n_pump_b;
        n_out.gauge_drive  = n_gauge;
        n_out.mode         = n_mode;
        n_out.gauge_fault  = n_gauge_fault;
        n_out.system_fault = n_sys_fault;
        n_out.event_res    = n_event;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fore_trip <= 16'd40000;
            r_fore_safe <= 16'd20000;
            r_uhv_trip  <= 16'd30000;
            r_warmup    <= 24'd10000;
            r_fore_stbl <= 24'd2000;
            r_ok_deb    <= 24'd1000;
            r_lost_tmo  <= 24'd15000;
            r_grace     <= 24'd5000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FORE_TRIP:   r_fore_trip <= i_cfg_data[C_LEVEL_BITS-1:0];
                CFG_FORE_SAFE:   r_fore_safe <= i_cfg_data[C_LEVEL_BITS-1:0];
                CFG_UHV_TRIP:    r_uhv_trip  <= i_cfg_data[C_LEVEL_BITS-1:0];
                CFG_WARMUP:      r_warmup    <= i_cfg_data[C_MS_BITS-1:0];
                CFG_FORE_STBL:   r_fore_stbl <= i_cfg_data[C_MS_BITS-1:0];
                CFG_OK_DEBOUNCE: r_ok_deb    <= i_cfg_data[C_MS_BITS-1:0];
                CFG_LOST_TMO:    r_lost_tmo  <= i_cfg_data[C_MS_BITS-1:0];
                CFG_GAUGE_GRACE: r_grace     <= i_cfg_data[C_MS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_WARM;
            r_gauge_fault <= 1'b0;
            r_sys_fault   <= 1'b0;
            r_pump_a      <= 1'b0;
            r_pump_b      <= 1'b0;
            r_gauge       <= 1'b0;
            r_gauge_seen  <= 1'b0;
            r_boot_t      <= '0;
            r_fsafe_t     <= '0;
            r_gon_t       <= '0;
            r_ok_a_t      <= '0;
            r_ok_b_t      <= '0;
            r_lost_a_t    <= '0;
            r_lost_b_t    <= '0;
        end else if (w_take) begin
            r_mode        <= n_mode;
            r_gauge_fault <= n_gauge_fault;
            r_sys_fault   <= n_sys_fault;
            r_pump_a      <= n_pump_a;
            r_pump_b      <= n_pump_b;
            r_gauge       <= n_gauge;
            r_gauge_seen  <= n_gauge_seen;
            r_boot_t      <= n_boot_t;
            r_fsafe_t     <= n_fsafe_t;
            r_gon_t       <= n_gon_t;
            r_ok_a_t      <= n_ok_a_t;
            r_ok_b_t      <= n_ok_b_t;
            r_lost_a_t    <= n_lost_a_t;
            r_lost_b_t    <= n_lost_b_t;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    a_fault_relays_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sys_fault |-> (!r_pump_a && !r_pump_b && !r_gauge))
        else $error("relay on while system fault latched");

    a_gauge_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gauge |-> (r_mode == MODE_RUN && r_gauge_seen && !r_gauge_fault))
        else $error("gauge supply on outside run");

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_out_valid)
        else $error("taken transaction produced no result");

endmodule

/* sv/vacuum_pump_interlock_controller_top.sv */
`timescale 1ns / 1ps
// Flow: an accepted transaction waits in the queue; the sequencer takes it from the head and
// registers its result once the result register is free; a stalling receiver delays that.
// Throughput: one transaction per cycle while the receiver does not stall; a stalled
// receiver fills the two-entry queue and then stalls the input.
// Reset: synchronous, active low; empties the queue, drops the result valid, clears all
// timers and fault flags, sets mode to warm-up and loads the default configuration levels.
module vacuum_pump_interlock_controller_top #(
    parameter int TIMER_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  vpic_pkg::t_in_item                   i_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output vpic_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_we,
    input  logic [vpic_pkg::C_CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [vpic_pkg::C_CFG_DATA_BITS-1:0] i_cfg_data
);
    import vpic_pkg::*;

    t_head w_head;
    logic  w_pop;

    // Front: classify and queue transactions
    vpic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // Back: interlock sequencer and result register
    vpic_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule
